FILE: design/raab_pkg.sv
// raab_pkg: shared constants for the ray versus axis-aligned box unit.
// No dependencies; used by the top level and its checker.
package raab_pkg;

  localparam int COORD_WIDTH = 32;                // default coordinate width
  localparam int TOL_WIDTH   = 16;                // edge tolerance register width
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd66;  // about 0.001 in Q16.16
  localparam int NUM_AXES    = 3;
  localparam int NUM_PLANES  = 6;                 // x max, x min, y max, y min, z max, z min

endpackage

FILE: design/raab_div.sv
// raab_div: pipelined restoring divider, one quotient bit per stage.
// Flags quotients that do not fit in QW bits. No package dependency.
module raab_div #(
  parameter int NW = 65,
  parameter int DW = 32,
  parameter int QW = 35
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  localparam int CW = DW + QW;   // compare width, holds den << QW

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic          ovf_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int Bit = QW - 1 - s;
    logic [NW-1:0] rem_in, rem_d;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in, quo_d;
    logic          ovf_in;
    logic [CW-1:0] shifted;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      // quotient would need more than QW bits
      assign ovf_in = CW'(num_i) >= (CW'(den_i) << QW);
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
      assign ovf_in = ovf_q[s-1];
    end

    always_comb begin
      shifted  = CW'(den_in) << Bit;
      ge       = CW'(rem_in) >= shifted;
      rem_d    = ge ? NW'(CW'(rem_in) - shifted) : rem_in;
      quo_d    = quo_in;
      quo_d[Bit] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        den_q[s] <= den_in;
        quo_q[s] <= quo_d;
        ovf_q[s] <= ovf_in;
      end
    end
  end

  assign quo_o = quo_q[QW-1];
  assign ovf_o = ovf_q[QW-1];

endmodule

FILE: design/raab_sqrt.sv
// raab_sqrt: pipelined integer square root (floor), one root bit per stage.
// No package dependency.
module raab_sqrt #(
  parameter int IW = 72,
  parameter int RW = 36
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [IW-1:0] rad_i,
  output logic [RW-1:0] root_o
);

  localparam int XW = IW + 1;

  logic [IW-1:0] op_q  [RW];
  logic [XW-1:0] res_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int Sh = 2 * (RW - 1 - s);
    logic [IW-1:0] op_in, op_d;
    logic [XW-1:0] res_in, res_d, one, trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign op_in  = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign op_in  = op_q[s-1];
      assign res_in = res_q[s-1];
    end

    always_comb begin
      one   = XW'(1) << Sh;
      trial = res_in + one;
      ge    = XW'(op_in) >= trial;
      op_d  = ge ? IW'(XW'(op_in) - trial) : op_in;
      res_d = ge ? ((res_in >> 1) + one) : (res_in >> 1);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        op_q[s]  <= op_d;
        res_q[s] <= res_d;
      end
    end
  end

  assign root_o = res_q[RW-1][RW-1:0];

endmodule

FILE: design/ray_aabb_3d_intersect_unit.sv
// ray_aabb_3d_intersect_unit: ray versus axis-aligned box, signed fixed point.
// Depends on raab_pkg, raab_div and raab_sqrt.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------------
//  in       | in_valid_i / in_ready_o  | origin_*, dir_*, box_min_*, box_max_*
//  out      | out_valid_o / out_ready_i| hit, hit_x/y/z, distance
//  cfg      | cfg_we_i (no wait)       | cfg_wdata_i -> edge tolerance
//
// One transaction enters per cycle while the output buffer has room. The pipeline has
// COORD_WIDTH+3 divider stages, COORD_WIDTH+4 square root stages, 11 others and
// the output buffer register.
// The whole pipeline advances on one enable, held only while the two-entry
// output buffer is full; a stall freezes every stage, nothing is lost or repeated.
// Reset clears valid bits, buffer pointers and sets the tolerance to its default.
module ray_aabb_3d_intersect_unit #(
  parameter int COORD_WIDTH = raab_pkg::COORD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [raab_pkg::TOL_WIDTH-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_z_i,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic signed [COORD_WIDTH-1:0] hit_x_o,
  output logic signed [COORD_WIDTH-1:0] hit_y_o,
  output logic signed [COORD_WIDTH-1:0] hit_z_o,
  output logic        [COORD_WIDTH:0]   distance_o
);

  localparam int W   = COORD_WIDTH;
  localparam int NA  = raab_pkg::NUM_AXES;
  localparam int NP  = raab_pkg::NUM_PLANES;
  localparam int TW  = raab_pkg::TOL_WIDTH;
  localparam int DFW = W + 1;            // |bound - origin|
  localparam int DL  = DFW / 2;          // product split, low part of |diff|
  localparam int DH  = DFW - DL;
  localparam int NW  = W + DFW;          // |dir| * |diff|
  localparam int QW  = W + 3;            // quotient magnitude
  localparam int PW  = W + 5;            // signed plane point
  localparam int LB  = QW / 2;           // square split
  localparam int HB  = QW - LB;
  localparam int SW  = 2 * QW + 2;       // sum of three squares
  localparam int RW  = W + 4;            // root width
  localparam logic [QW-1:0] LIM = QW'(1) << (W + 2);

  typedef struct packed {
    logic [NA-1:0][W-1:0] o;
    logic [NA-1:0][W-1:0] lo;
    logic [NA-1:0][W-1:0] hi;
    logic [NP-1:0][NA-1:0] neg;
    logic [NP-1:0]         skip;
  } side_t;

  typedef struct packed {
    logic                 ok;
    logic [SW-1:0]        dsq;
    logic [NA-1:0][W-1:0] pc;
  } cand_t;

  typedef struct packed {
    logic                 hit;
    logic [NA-1:0][W-1:0] pc;
  } rs_t;

  typedef struct packed {
    logic                 hit;
    logic [NA-1:0][W-1:0] pc;
    logic [W:0]           rng;
  } out_t;

  // later plane wins a tie
  function automatic cand_t pick(cand_t e, cand_t l);
    return (l.ok && (!e.ok || l.dsq <= e.dsq)) ? l : e;
  endfunction

  // ---------------- control ----------------
  logic          adv;
  logic [1:0]    cnt_q;
  logic          wr_ptr_q, rd_ptr_q;
  logic [TW-1:0] tol_q;

  assign adv        = (cnt_q != 2'd2);
  assign in_ready_o = adv;

  logic [3:0]    vld_q;   // A, B, C, C2
  logic [QW-1:0] vdiv_q;
  logic [3:0]    vpost_q; // D, E, F, G
  logic [2:0]    vtree_q;
  logic [RW-1:0] vsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vdiv_q  <= '0;
      vpost_q <= '0;
      vtree_q <= '0;
      vsq_q   <= '0;
      tol_q   <= raab_pkg::TOL_RESET;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (adv) begin
        vld_q   <= {vld_q[2:0], in_valid_i};
        vdiv_q  <= {vdiv_q[QW-2:0], vld_q[3]};
        vpost_q <= {vpost_q[2:0], vdiv_q[QW-1]};
        vtree_q <= {vtree_q[1:0], vpost_q[3]};
        vsq_q   <= {vsq_q[RW-2:0], vtree_q[2]};
      end
    end
  end

  // ---------------- stage A: capture ----------------
  logic [NA-1:0][W-1:0] o_a_q, d_a_q, lo_a_q, hi_a_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_a_q  <= {origin_z_i, origin_y_i, origin_x_i};
      d_a_q  <= {dir_z_i, dir_y_i, dir_x_i};
      lo_a_q <= {box_min_z_i, box_min_y_i, box_min_x_i};
      hi_a_q <= {box_max_z_i, box_max_y_i, box_max_x_i};
    end
  end

  // ---------------- stage B: plane offsets, magnitudes, signs ----------------
  logic [NA-1:0][W-1:0]   dm_b_d, dm_b_q;
  logic [NP-1:0][DFW-1:0] dfm_b_d, dfm_b_q;
  side_t                  sd_b_d, sd_b_q;

  always_comb begin : b_comb
    int a;
    logic [W-1:0]          bnd;
    logic signed [DFW-1:0] diff;
    sd_b_d.o  = o_a_q;
    sd_b_d.lo = lo_a_q;
    sd_b_d.hi = hi_a_q;
    for (int k = 0; k < NA; k++) begin
      dm_b_d[k] = d_a_q[k][W-1] ? W'(-d_a_q[k]) : d_a_q[k];
    end
    for (int pl = 0; pl < NP; pl++) begin
      a    = pl >> 1;
      bnd  = pl[0] ? lo_a_q[a] : hi_a_q[a];
      diff = $signed({bnd[W-1], bnd}) - $signed({o_a_q[a][W-1], o_a_q[a]});
      dfm_b_d[pl]     = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
      sd_b_d.skip[pl] = (d_a_q[a] == '0);
      for (int k = 0; k < NA; k++) begin
        sd_b_d.neg[pl][k] = d_a_q[k][W-1] ^ diff[DFW-1] ^ d_a_q[a][W-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dm_b_q  <= dm_b_d;
      dfm_b_q <= dfm_b_d;
      sd_b_q  <= sd_b_d;
    end
  end

  // ---------------- stage C: split products ----------------
  logic [NA-1:0][W-1:0]                dm_c_q;
  logic [NP-1:0][NA-1:0][W+DL-1:0]     ppl_c_q;
  logic [NP-1:0][NA-1:0][W+DH-1:0]     pph_c_q;
  side_t                               sd_c_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dm_c_q <= dm_b_q;
      sd_c_q <= sd_b_q;
      for (int pl = 0; pl < NP; pl++) begin
        for (int k = 0; k < NA; k++) begin
          ppl_c_q[pl][k] <= (W+DL)'(dm_b_q[k]) * (W+DL)'(dfm_b_q[pl][DL-1:0]);
          pph_c_q[pl][k] <= (W+DH)'(dm_b_q[k]) * (W+DH)'(dfm_b_q[pl][DFW-1:DL]);
        end
      end
    end
  end

  // ---------------- stage C2: numerators and divisors ----------------
  logic [NP-1:0][NA-1:0][NW-1:0] num_q;
  logic [NP-1:0][W-1:0]          den_q;
  side_t                         sd_c2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_c2_q <= sd_c_q;
      for (int pl = 0; pl < NP; pl++) begin
        den_q[pl] <= dm_c_q[pl >> 1];
        for (int k = 0; k < NA; k++) begin
          num_q[pl][k] <= (NW'(pph_c_q[pl][k]) << DL) + NW'(ppl_c_q[pl][k]);
        end
      end
    end
  end

  // ---------------- divider bank ----------------
  logic [NP-1:0][NA-1:0][QW-1:0] quo_w;
  logic [NP-1:0][NA-1:0]         ovf_w;

  for (genvar pl = 0; pl < NP; pl++) begin : g_pl
    for (genvar k = 0; k < NA; k++) begin : g_ax
      raab_div #(
        .NW(NW),
        .DW(W),
        .QW(QW)
      ) u_div (
        .clk_i(clk_i),
        .en_i (adv),
        .num_i(num_q[pl][k]),
        .den_i(den_q[pl]),
        .quo_o(quo_w[pl][k]),
        .ovf_o(ovf_w[pl][k])
      );
    end
  end

  side_t sd_dly_q [QW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_dly_q[0] <= sd_c2_q;
      for (int i = 1; i < QW; i++) begin
        sd_dly_q[i] <= sd_dly_q[i-1];
      end
    end
  end

  // ---------------- stage D: plane points, inside test, saturation ----------------
  side_t                         sd_d;
  logic [NP-1:0]                 ok_d_d, ok_d_q;
  logic [NP-1:0][NA-1:0][W-1:0]  pc_d_d, pc_d_q;
  logic [NP-1:0][NA-1:0][QW-1:0] q_d_q;

  assign sd_d = sd_dly_q[QW-1];

  always_comb begin : d_comb
    logic signed [PW-1:0] qs, p, lo_t, hi_t, tol_s, o_s;
    logic                 good;
    tol_s = $signed({{(PW-TW){1'b0}}, tol_q});
    for (int pl = 0; pl < NP; pl++) begin
      good = !sd_d.skip[pl];
      for (int k = 0; k < NA; k++) begin
        qs   = $signed({{(PW-QW){1'b0}}, quo_w[pl][k]});
        qs   = sd_d.neg[pl][k] ? -qs : qs;
        o_s  = $signed({{(PW-W){sd_d.o[k][W-1]}}, sd_d.o[k]});
        p    = o_s + qs;
        lo_t = $signed({{(PW-W){sd_d.lo[k][W-1]}}, sd_d.lo[k]}) - tol_s;
        hi_t = $signed({{(PW-W){sd_d.hi[k][W-1]}}, sd_d.hi[k]}) + tol_s;
        if (ovf_w[pl][k] || quo_w[pl][k] > LIM || p < lo_t || p > hi_t) begin
          good = 1'b0;
        end
        if ((&p[PW-1:W-1]) || !(|p[PW-1:W-1])) begin
          pc_d_d[pl][k] = p[W-1:0];
        end else if (p[PW-1]) begin
          pc_d_d[pl][k] = {1'b1, {(W-1){1'b0}}};
        end else begin
          pc_d_d[pl][k] = {1'b0, {(W-1){1'b1}}};
        end
      end
      ok_d_d[pl] = good;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_d_q <= ok_d_d;
      pc_d_q <= pc_d_d;
      q_d_q  <= quo_w;
    end
  end

  // ---------------- stage E: square partial products ----------------
  logic [NP-1:0]                   ok_e_q;
  logic [NP-1:0][NA-1:0][W-1:0]    pc_e_q;
  logic [NP-1:0][NA-1:0][2*HB-1:0] hh_e_q;
  logic [NP-1:0][NA-1:0][QW-1:0]   hl_e_q;
  logic [NP-1:0][NA-1:0][2*LB-1:0] ll_e_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_e_q <= ok_d_q;
      pc_e_q <= pc_d_q;
      for (int pl = 0; pl < NP; pl++) begin
        for (int k = 0; k < NA; k++) begin
          hh_e_q[pl][k] <= (2*HB)'(q_d_q[pl][k][QW-1:LB]) * (2*HB)'(q_d_q[pl][k][QW-1:LB]);
          hl_e_q[pl][k] <= QW'(q_d_q[pl][k][QW-1:LB]) * QW'(q_d_q[pl][k][LB-1:0]);
          ll_e_q[pl][k] <= (2*LB)'(q_d_q[pl][k][LB-1:0]) * (2*LB)'(q_d_q[pl][k][LB-1:0]);
        end
      end
    end
  end

  // ---------------- stage F: squares ----------------
  logic [NP-1:0]                   ok_f_q;
  logic [NP-1:0][NA-1:0][W-1:0]    pc_f_q;
  logic [NP-1:0][NA-1:0][2*QW-1:0] sq_f_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_f_q <= ok_e_q;
      pc_f_q <= pc_e_q;
      for (int pl = 0; pl < NP; pl++) begin
        for (int k = 0; k < NA; k++) begin
          sq_f_q[pl][k] <= ((2*QW)'(hh_e_q[pl][k]) << (2*LB))
                         + ((2*QW)'(hl_e_q[pl][k]) << (LB+1))
                         + (2*QW)'(ll_e_q[pl][k]);
        end
      end
    end
  end

  // ---------------- stage G: squared distance per plane ----------------
  cand_t [NP-1:0] cand_g_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int pl = 0; pl < NP; pl++) begin
        cand_g_q[pl].ok  <= ok_f_q[pl];
        cand_g_q[pl].pc  <= pc_f_q[pl];
        cand_g_q[pl].dsq <= SW'(sq_f_q[pl][0]) + SW'(sq_f_q[pl][1]) + SW'(sq_f_q[pl][2]);
      end
    end
  end

  // ---------------- nearest plane, registered tree ----------------
  cand_t [2:0] t1_q;
  cand_t [1:0] t2_q;
  cand_t       t3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q[0] <= pick(cand_g_q[0], cand_g_q[1]);
      t1_q[1] <= pick(cand_g_q[2], cand_g_q[3]);
      t1_q[2] <= pick(cand_g_q[4], cand_g_q[5]);
      t2_q[0] <= pick(t1_q[0], t1_q[1]);
      t2_q[1] <= t1_q[2];
      t3_q    <= pick(t2_q[0], t2_q[1]);
    end
  end

  // ---------------- square root ----------------
  logic [RW-1:0] root_w;

  raab_sqrt #(
    .IW(SW),
    .RW(RW)
  ) u_sqrt (
    .clk_i (clk_i),
    .en_i  (adv),
    .rad_i (t3_q.ok ? t3_q.dsq : '0),
    .root_o(root_w)
  );

  rs_t rs_dly_q [RW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rs_dly_q[0] <= '{hit: t3_q.ok, pc: t3_q.pc};
      for (int i = 1; i < RW; i++) begin
        rs_dly_q[i] <= rs_dly_q[i-1];
      end
    end
  end

  // ---------------- result formatting ----------------
  out_t res;

  always_comb begin
    res.hit = rs_dly_q[RW-1].hit;
    if (rs_dly_q[RW-1].hit) begin
      res.pc  = rs_dly_q[RW-1].pc;
      res.rng = (|root_w[RW-1:W+1]) ? '1 : root_w[W:0];
    end else begin
      res.pc  = '0;
      res.rng = '1;
    end
  end

  // ---------------- output buffer (two entries) ----------------
  out_t skid_q [2];
  logic push, pop;

  assign push = adv && vsq_q[RW-1];
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      skid_q[wr_ptr_q] <= res;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign hit_o       = skid_q[rd_ptr_q].hit;
  assign hit_x_o     = skid_q[rd_ptr_q].pc[0];
  assign hit_y_o     = skid_q[rd_ptr_q].pc[1];
  assign hit_z_o     = skid_q[rd_ptr_q].pc[2];
  assign distance_o  = skid_q[rd_ptr_q].rng;

endmodule

FILE: design/raab_checker.sv
// raab_checker: port-level checks for ray_aabb_3d_intersect_unit, with its bind.
// Depends on raab_pkg.
module raab_checker #(
  parameter int COORD_WIDTH = raab_pkg::COORD_WIDTH
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          hit_o,
  input logic signed [COORD_WIDTH-1:0] hit_x_o,
  input logic signed [COORD_WIDTH-1:0] hit_y_o,
  input logic signed [COORD_WIDTH-1:0] hit_z_o,
  input logic        [COORD_WIDTH:0]   distance_o
);

  // transactions accepted but not yet delivered
  logic [15:0] pend_q;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 16'(in_acc) - 16'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o) && $stable(hit_x_o))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result without a pending transaction");

  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> distance_o == '1 && hit_x_o == '0 && hit_y_o == '0
                              && hit_z_o == '0)
    else $error("miss result with nonzero point or distance");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

endmodule

bind ray_aabb_3d_intersect_unit raab_checker #(.COORD_WIDTH(COORD_WIDTH)) u_raab_checker (.*);
